// ===== rtl/serial_tx_queue_with_decimal_defines.svh =====
// Assertion macros shared by the checker of the serial transmit queue.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef SERIAL_TX_QUEUE_WITH_DECIMAL_DEFINES_SVH
`define SERIAL_TX_QUEUE_WITH_DECIMAL_DEFINES_SVH

// Same-cycle implication, checked only outside reset.
`define STQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked only outside reset.
`define STQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/stq_pkg.sv =====
// Shared types and constants of the serial transmit queue.
// Depends on nothing; used by the input interface, controller, datapath and top level.
`timescale 1ns / 1ps

package stq_pkg;

    localparam int unsigned C_DEPTH  = 16;
    localparam int unsigned C_DIGITS = 5;
    localparam int unsigned C_POS_W  = $clog2(C_DIGITS);

    typedef logic [1:0]         t_func;
    typedef logic [C_POS_W-1:0] t_pos;
    typedef logic [16:0]        t_wide;

    localparam t_func C_FUNC_PUT_BYTE   = 2'd0;
    localparam t_func C_FUNC_PUT_NUMBER = 2'd1;
    localparam t_func C_FUNC_TX_READY   = 2'd2;

    localparam logic [7:0] C_ASCII_ZERO = 8'h30;
    localparam t_pos       C_POS_TOP    = t_pos'(C_DIGITS - 1);

    // Multiples of each decimal weight: C_STEP[k][j] = j * 10**k.
    localparam t_wide C_STEP [C_DIGITS][10] = '{
        '{17'd0, 17'd1, 17'd2, 17'd3, 17'd4, 17'd5, 17'd6, 17'd7, 17'd8, 17'd9},
        '{17'd0, 17'd10, 17'd20, 17'd30, 17'd40, 17'd50, 17'd60, 17'd70, 17'd80,
          17'd90},
        '{17'd0, 17'd100, 17'd200, 17'd300, 17'd400, 17'd500, 17'd600, 17'd700,
          17'd800, 17'd900},
        '{17'd0, 17'd1000, 17'd2000, 17'd3000, 17'd4000, 17'd5000, 17'd6000,
          17'd7000, 17'd8000, 17'd9000},
        '{17'd0, 17'd10000, 17'd20000, 17'd30000, 17'd40000, 17'd50000,
          17'd60000, 17'd70000, 17'd80000, 17'd90000}
    };

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic put_byte;
        logic num_step;
        logic tx_start;
        logic tx_capture;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_func func;
        logic  empty;
        logic  num_done;
        logic  res_busy;
    } t_stat;

    // Decimal digit at weight 10**k of a value known to be below 10**(k+1).
    function automatic logic [3:0] f_digit(input logic [15:0] v, input t_pos k);
        logic [3:0] d;
        d = 4'd0;
        for (int j = 1; j < 10; j++) begin
            if ({1'b0, v} >= C_STEP[k][4'(j)]) begin
                d = 4'(j);
            end
        end
        return d;
    endfunction

endpackage

// ===== rtl/stq_if.sv =====
// Valid/ready channel interfaces of the serial transmit queue.
// Depends on stq_pkg.
`timescale 1ns / 1ps

interface stq_in_if;
    import stq_pkg::*;
    logic        valid;
    logic        ready;
    t_func       func;
    logic [7:0]  char_byte;
    logic [15:0] number;
    modport source (output valid, func, char_byte, number, input ready);
    modport sink   (input valid, func, char_byte, number, output ready);
endinterface

interface stq_out_if;
    logic       valid;
    logic       ready;
    logic       accepted;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       drain_enabled;
    modport source (output valid, accepted, out_valid, out_byte, drain_enabled, input ready);
    modport sink   (input valid, accepted, out_valid, out_byte, drain_enabled, output ready);
endinterface

// ===== rtl/serial_tx_queue_with_decimal.sv =====
// Top level of the serial transmit queue with decimal number output.
// Depends on stq_pkg, stq_if, stq_ctrl and stq_dp.
`timescale 1ns / 1ps

// The block buffers bytes for a serial transmitter in a ring of DEPTH slots,
// of which DEPTH-1 can hold data. Requests arrive as beats on i_in: a put
// byte, a put number (queued as ASCII decimal, most significant digit first,
// without leading zeros), or a transmitter-ready event that dequeues the
// oldest byte or, on an empty queue, clears the drain-enable flag. Every
// request produces exactly one result beat on o_out carrying the accepted
// flag, the dequeued byte with its valid flag, and the drain flag.
// One request is processed at a time. A transmitter-ready event on a
// non-empty queue passes through an extra state for the registered read
// of the byte RAM, and a put number is paced by the digit unit, which
// produces one decimal digit per cycle over the five decimal weights and
// stores every digit but the leading zeros; a number cut off by a full
// queue ends sooner. A result waiting in the output register does not
// block acceptance of the next request; only the finishing step of that
// next request waits until the receiver has taken the previous beat.
// Synchronous reset empties the queue, clears the drain flag and drops any
// pending result; the byte RAM itself is not cleared.

module serial_tx_queue_with_decimal #(
    parameter int unsigned DEPTH = stq_pkg::C_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stq_in_if.sink     i_in,
    stq_out_if.source  o_out
);

    import stq_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    // The controller only sequences; all storage lives in the datapath.
    stq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    stq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_func          (i_in.func),
        .i_char_byte     (i_in.char_byte),
        .i_number        (i_in.number),
        .o_res_valid     (o_out.valid),
        .i_res_ready     (o_out.ready),
        .o_accepted      (o_out.accepted),
        .o_out_valid     (o_out.out_valid),
        .o_out_byte      (o_out.out_byte),
        .o_drain_enabled (o_out.drain_enabled)
    );

endmodule

// ===== rtl/stq_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module stq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/stq_ctrl.sv =====
// Sequencing state machine of the serial transmit queue.
// Depends on stq_pkg; drives the datapath through t_cmd and reads t_stat.
`timescale 1ns / 1ps

module stq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  stq_pkg::t_stat i_stat,
    output stq_pkg::t_cmd  o_cmd
);

    import stq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_NUM,
        S_TXCAP,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   n_in_ready;
    t_cmd   w_cmd;

    always_comb begin
        w_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_stat.func)
                    C_FUNC_PUT_BYTE: begin
                        w_cmd.put_byte = 1'b1;
                        n_state        = S_DONE;
                    end
                    C_FUNC_PUT_NUMBER: begin
                        w_cmd.num_step = 1'b1;
                        n_state        = i_stat.num_done ? S_DONE : S_NUM;
                    end
                    C_FUNC_TX_READY: begin
                        w_cmd.tx_start = 1'b1;
                        n_state        = i_stat.empty ? S_DONE : S_TXCAP;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_NUM: begin
                w_cmd.num_step = 1'b1;
                if (i_stat.num_done) begin
                    n_state = S_DONE;
                end
            end
            S_TXCAP: begin
                w_cmd.tx_capture = 1'b1;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (!i_stat.res_busy) begin
                    w_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_in_ready = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= n_in_ready;
        end
    end

    assign o_in_ready = r_in_ready;
    assign o_cmd      = w_cmd;

endmodule

// ===== rtl/stq_dp.sv =====
// Datapath of the serial transmit queue: ring indices, byte RAM, decimal digit
// unit and output register. Depends on stq_pkg and stq_ram.
`timescale 1ns / 1ps

module stq_dp #(
    parameter int unsigned DEPTH = stq_pkg::C_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  stq_pkg::t_cmd  i_cmd,
    output stq_pkg::t_stat o_stat,
    input  stq_pkg::t_func i_func,
    input  logic [7:0]     i_char_byte,
    input  logic [15:0]    i_number,
    output logic           o_res_valid,
    input  logic           i_res_ready,
    output logic           o_accepted,
    output logic           o_out_valid,
    output logic [7:0]     o_out_byte,
    output logic           o_drain_enabled
);

    import stq_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);
    typedef logic [AW-1:0] t_idx;
    localparam t_idx C_LAST = t_idx'(DEPTH - 1);

    // Queue control.
    t_idx r_wr;
    t_idx r_rd;
    logic r_drain;
    logic r_res_valid;

    // Current item.
    t_func       r_func;
    logic [7:0]  r_char;
    logic [15:0] r_num;
    t_pos        r_pos;
    logic        r_started;
    logic        r_acc;
    logic        r_obv;
    logic [7:0]  r_ob;

    // Output register.
    logic       r_res_acc;
    logic       r_res_ov;
    logic [7:0] r_res_ob;
    logic       r_res_drain;

    t_idx        w_wr_next;
    t_idx        w_rd_next;
    logic        w_full;
    logic        w_empty;
    logic [3:0]  w_digit;
    t_wide       w_sub;
    logic        w_emit;
    logic        w_we;
    logic [7:0]  w_wdata;
    logic        w_re;
    logic [7:0]  w_rdata;

    assign w_wr_next = (r_wr == C_LAST) ? '0 : r_wr + t_idx'(1);
    assign w_rd_next = (r_rd == C_LAST) ? '0 : r_rd + t_idx'(1);
    assign w_full    = (w_wr_next == r_rd);
    assign w_empty   = (r_wr == r_rd);

    // One decimal digit per step, most significant weight first.
    assign w_digit = f_digit(r_num, r_pos);
    assign w_sub   = {1'b0, r_num} - C_STEP[r_pos][w_digit];
    // Leading zeros are skipped, but the units digit always goes out.
    assign w_emit  = r_started || (w_digit != 4'd0) || (r_pos == '0);

    assign w_we    = (i_cmd.put_byte && !w_full) || (i_cmd.num_step && w_emit && !w_full);
    assign w_wdata = i_cmd.put_byte ? r_char : (C_ASCII_ZERO + {4'b0000, w_digit});
    assign w_re    = i_cmd.tx_start && !w_empty;

    stq_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_wr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (r_rd),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr        <= '0;
            r_rd        <= '0;
            r_drain     <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (w_we) begin
                r_wr    <= w_wr_next;
                r_drain <= 1'b1;
            end
            if (i_cmd.tx_start) begin
                if (w_empty) begin
                    r_drain <= 1'b0;
                end else begin
                    r_rd <= w_rd_next;
                end
            end
            if (i_cmd.finish) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func    <= i_func;
            r_char    <= i_char_byte;
            r_num     <= i_number;
            r_pos     <= C_POS_TOP;
            r_started <= 1'b0;
            r_acc     <= (i_func == C_FUNC_PUT_BYTE) || (i_func == C_FUNC_PUT_NUMBER);
            r_obv     <= 1'b0;
            r_ob      <= 8'h00;
        end
        if (i_cmd.put_byte && w_full) begin
            r_acc <= 1'b0;
        end
        if (i_cmd.num_step) begin
            r_num <= w_sub[15:0];
            r_pos <= r_pos - t_pos'(1);
            if (w_emit) begin
                r_started <= 1'b1;
                if (w_full) begin
                    r_acc <= 1'b0;
                end
            end
        end
        if (i_cmd.tx_start) begin
            r_obv <= !w_empty;
        end
        if (i_cmd.tx_capture) begin
            r_ob <= w_rdata;
        end
        if (i_cmd.finish) begin
            r_res_acc   <= r_acc;
            r_res_ov    <= r_obv;
            r_res_ob    <= r_ob;
            r_res_drain <= r_drain;
        end
    end

    assign o_stat.func     = r_func;
    assign o_stat.empty    = w_empty;
    assign o_stat.num_done = (r_pos == '0) || (w_emit && w_full);
    assign o_stat.res_busy = r_res_valid && !i_res_ready;

    assign o_res_valid     = r_res_valid;
    assign o_accepted      = r_res_acc;
    assign o_out_valid     = r_res_ov;
    assign o_out_byte      = r_res_ob;
    assign o_drain_enabled = r_res_drain;

endmodule

// ===== rtl/stq_checker.sv =====
// Port-level assertions for the serial transmit queue, bound to the top level.
// Depends on serial_tx_queue_with_decimal_defines.svh.
`timescale 1ns / 1ps
`include "serial_tx_queue_with_decimal_defines.svh"

module stq_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_accepted,
    input logic       i_out_flag,
    input logic [7:0] i_out_byte,
    input logic       i_drain
);

    // A stalled result beat keeps its contents.
    `STQ_ASSERT_NXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_accepted) && $stable(i_out_flag) && $stable(i_out_byte) && $stable(i_drain), "result beat changed while stalled")

    // Requests are handled one at a time, so ready drops after an accepted beat.
    `STQ_ASSERT_NXT(a_one_at_a_time, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "request accepted while busy")

    // Any successful put or dequeue leaves the drain flag set.
    `STQ_ASSERT_IMP(a_drain_set, i_clk, i_rst_n, i_out_valid && (i_accepted || i_out_flag), i_drain, "drain flag low after queue activity")

    // A dequeue never also reports a successful put.
    `STQ_ASSERT_IMP(a_kind, i_clk, i_rst_n, i_out_valid && i_out_flag, !i_accepted, "dequeue reported as accepted put")

    // No result is pending right after reset.
    `STQ_ASSERT_IMP(a_reset_clear, i_clk, i_rst_n, $rose(i_rst_n), !i_out_valid, "result pending after reset")

endmodule

bind serial_tx_queue_with_decimal stq_checker u_stq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_accepted  (o_out.accepted),
    .i_out_flag  (o_out.out_valid),
    .i_out_byte  (o_out.out_byte),
    .i_drain     (o_out.drain_enabled)
);
